/* sv/steq_pkg.sv */
// ----------------------------------------------------------------------------
// steq_pkg
// Shared widths, reset values, register indexes and state codes for the
// three-band equalizer.
// ----------------------------------------------------------------------------
package steq_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 18;
    localparam int POLE_W        = 40;
    localparam int STAGES        = 4;
    localparam int DELAY         = 3;
    localparam int COEF_FRAC     = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CHANNELS_DEF  = 2;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [COEF_W-1:0] LOW_COEF_RST  = 18'd7545;
    localparam logic [COEF_W-1:0] HIGH_COEF_RST = 18'd42132;
    localparam logic [COEF_W-1:0] GAIN_RST      = 18'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_COEF  = 3'd0,
        REG_HIGH_COEF = 3'd1,
        REG_LOW_GAIN  = 3'd2,
        REG_MID_GAIN  = 3'd3,
        REG_HIGH_GAIN = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_UPDATE,
        ST_OPND,
        ST_OMUL_LO,
        ST_OMUL_HI,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        TERM_LOW,
        TERM_MID,
        TERM_HIGH
    } t_term;

    typedef enum logic {
        BAND_LOW,
        BAND_HIGH
    } t_band;

endpackage

/* sv/stereo_three_band_equalizer_unit.sv */
// ----------------------------------------------------------------------------
// stereo_three_band_equalizer_unit
// Multi-channel three-band equalizer built around one shared multiply-
// accumulate unit. Per channel, an item goes through eight one-pole updates
// (difference, low product, high product, pole write), three band products
// (operand, low product, high product) and one rounding step, all through a
// single 25x19 signed multiplier feeding a 61-bit accumulator. o_s_tready
// stays low while an item is in work; a finished result sits in the output
// register, so the next item is taken while it waits. Poles are signed Q23.16
// by default (FRAC_BITS fraction bits in 40 bits), coefficients and gains
// unsigned with 16 fraction bits. The configuration channel is always ready;
// writes to indexes past the high gain are dropped.
// ----------------------------------------------------------------------------
module stereo_three_band_equalizer_unit #(
    parameter int CHANNELS  = steq_pkg::CHANNELS_DEF,
    parameter int FRAC_BITS = steq_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input items
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [CHANNELS*steq_pkg::SAMPLE_W-1:0] i_s_tdata,  // left_sample, right_sample, ...
    // result items
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [CHANNELS*steq_pkg::SAMPLE_W-1:0] o_m_tdata,  // left_out, right_out, ...
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [steq_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [steq_pkg::COEF_W-1:0]            i_cfg_data
);
    import steq_pkg::*;

    localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW        = $clog2(STAGES);
    localparam int DIFF_W    = POLE_W + 1;
    localparam int SPLIT     = 24;
    localparam int HI_W      = DIFF_W - SPLIT;
    localparam int MA_W      = SPLIT + 1;
    localparam int MB_W      = COEF_W + 1;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int ACC_W     = DIFF_W + COEF_W + 2;
    localparam int OUT_SHIFT = FRAC_BITS + COEF_FRAC;

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

    // control
    t_state              r_state, n_state;
    logic [CW-1:0]       r_ch, n_ch;
    logic [SW-1:0]       r_stage, n_stage;
    t_band               r_band, n_band;
    t_term               r_term, n_term;
    logic                r_m_tvalid, n_m_tvalid;

    // configuration
    logic [COEF_W-1:0]   r_low_coef, n_low_coef;
    logic [COEF_W-1:0]   r_high_coef, n_high_coef;
    logic [COEF_W-1:0]   r_low_gain, n_low_gain;
    logic [COEF_W-1:0]   r_mid_gain, n_mid_gain;
    logic [COEF_W-1:0]   r_high_gain, n_high_gain;

    // filter state
    logic signed [POLE_W-1:0]   r_low  [CHANNELS][STAGES];
    logic signed [POLE_W-1:0]   n_low  [CHANNELS][STAGES];
    logic signed [POLE_W-1:0]   r_high [CHANNELS][STAGES];
    logic signed [POLE_W-1:0]   n_high [CHANNELS][STAGES];
    logic signed [SAMPLE_W-1:0] r_hist [CHANNELS][DELAY];
    logic signed [SAMPLE_W-1:0] n_hist [CHANNELS][DELAY];

    // datapath
    logic signed [SAMPLE_W-1:0] r_samp [CHANNELS];
    logic signed [SAMPLE_W-1:0] n_samp [CHANNELS];
    logic signed [SAMPLE_W-1:0] r_res  [CHANNELS];
    logic signed [SAMPLE_W-1:0] n_res  [CHANNELS];
    logic signed [DIFF_W-1:0]   r_diff, n_diff;
    logic signed [POLE_W-1:0]   r_in, n_in;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic [CHANNELS*SAMPLE_W-1:0] r_m_tdata, n_m_tdata;

    logic signed [SAMPLE_W-1:0] samp_cur;
    logic signed [POLE_W-1:0]   x_val, low_rd, high_rd, pole_cur, in_val, d_val;
    logic signed [DIFF_W-1:0]   diff_val, h_val, m_val, opnd_val;
    logic [COEF_W-1:0]          coef_sel;
    logic                       mul_hi;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    prod_ext, acc_add;
    logic signed [ACC_W-1:0]    delta, pole_sum;
    logic                       pole_ovf;
    logic signed [POLE_W-1:0]   pole_new;
    logic signed [ACC_W-1:0]    bias, quot;
    logic signed [SAMPLE_W-1:0] res_val;
    logic                       last_stage, last_ch;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_cfg_ready = 1'b1;

    assign last_stage = (r_stage == SW'(STAGES - 1));
    assign last_ch    = (r_ch == CW'(CHANNELS - 1));

    // operand selection
    assign samp_cur = r_samp[r_ch];
    assign x_val    = $signed({{(POLE_W-SAMPLE_W){samp_cur[SAMPLE_W-1]}}, samp_cur}) <<< FRAC_BITS;
    assign low_rd   = r_low[r_ch][r_stage];
    assign high_rd  = r_high[r_ch][r_stage];
    assign pole_cur = (r_band == BAND_HIGH) ? high_rd : low_rd;
    assign in_val   = (r_stage == '0) ? x_val : r_in;
    assign diff_val = $signed({in_val[POLE_W-1], in_val}) - $signed({pole_cur[POLE_W-1], pole_cur});

    // delayed input, high band and mid band (m = d - (h + l) = hp - l)
    assign d_val = $signed({{(POLE_W-SAMPLE_W){r_hist[r_ch][DELAY-1][SAMPLE_W-1]}},
                            r_hist[r_ch][DELAY-1]}) <<< FRAC_BITS;
    assign h_val = $signed({d_val[POLE_W-1], d_val}) - $signed({high_rd[POLE_W-1], high_rd});
    assign m_val = $signed({high_rd[POLE_W-1], high_rd}) - $signed({low_rd[POLE_W-1], low_rd});

    always_comb begin
        case (r_term)
            TERM_LOW: opnd_val = $signed({low_rd[POLE_W-1], low_rd});
            TERM_MID: opnd_val = m_val;
            default:  opnd_val = h_val;
        endcase
    end

    always_comb begin
        if (r_state == ST_OMUL_LO || r_state == ST_OMUL_HI) begin
            case (r_term)
                TERM_LOW: coef_sel = r_low_gain;
                TERM_MID: coef_sel = r_mid_gain;
                default:  coef_sel = r_high_gain;
            endcase
        end else begin
            coef_sel = (r_band == BAND_HIGH) ? r_high_coef : r_low_coef;
        end
    end

    // shared multiply-accumulate: operand split into low 24 bits and signed top
    assign mul_hi   = (r_state == ST_MUL_HI) || (r_state == ST_OMUL_HI);
    assign mul_a    = mul_hi ? $signed({{(MA_W-HI_W){r_diff[DIFF_W-1]}}, r_diff[DIFF_W-1:SPLIT]})
                             : $signed({1'b0, r_diff[SPLIT-1:0]});
    assign mul_b    = $signed({1'b0, coef_sel});
    assign prod     = mul_a * mul_b;
    assign prod_ext = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
    assign acc_add  = r_acc + (mul_hi ? (prod_ext <<< SPLIT) : prod_ext);

    // pole update with floor shift and saturation
    assign delta    = r_acc >>> COEF_FRAC;
    assign pole_sum = $signed({{(ACC_W-POLE_W){pole_cur[POLE_W-1]}}, pole_cur}) + delta;
    assign pole_ovf = !((&pole_sum[ACC_W-1:POLE_W-1]) || !(|pole_sum[ACC_W-1:POLE_W-1]));
    assign pole_new = !pole_ovf ? pole_sum[POLE_W-1:0]
                    : (pole_sum[ACC_W-1] ? $signed({1'b1, {(POLE_W-1){1'b0}}})
                                         : $signed({1'b0, {(POLE_W-1){1'b1}}}));

    // truncate toward zero, then saturate to the sample range
    assign bias = r_acc[ACC_W-1] ? $signed((ACC_W'(1) << OUT_SHIFT) - ACC_W'(1)) : '0;
    assign quot = (r_acc + bias) >>> OUT_SHIFT;
    assign res_val = (quot > OUT_MAX) ? OUT_MAX[SAMPLE_W-1:0]
                   : (quot < OUT_MIN) ? OUT_MIN[SAMPLE_W-1:0]
                   : quot[SAMPLE_W-1:0];

    always_comb begin : next_state_logic
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_s_tvalid) n_state = ST_DIFF;
            ST_DIFF:    n_state = ST_MUL_LO;
            ST_MUL_LO:  n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = ST_UPDATE;
            ST_UPDATE:  n_state = (last_stage && r_band == BAND_HIGH) ? ST_OPND : ST_DIFF;
            ST_OPND:    n_state = ST_OMUL_LO;
            ST_OMUL_LO: n_state = ST_OMUL_HI;
            ST_OMUL_HI: n_state = (r_term == TERM_HIGH) ? ST_FINISH : ST_OPND;
            ST_FINISH:  n_state = last_ch ? ST_DONE : ST_DIFF;
            ST_DONE:    if (!r_m_tvalid || i_m_tready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin : datapath_logic
        n_ch        = r_ch;
        n_stage     = r_stage;
        n_band      = r_band;
        n_term      = r_term;
        n_low       = r_low;
        n_high      = r_high;
        n_hist      = r_hist;
        n_samp      = r_samp;
        n_res       = r_res;
        n_diff      = r_diff;
        n_in        = r_in;
        n_acc       = r_acc;
        n_m_tdata   = r_m_tdata;
        n_m_tvalid  = r_m_tvalid;
        n_low_coef  = r_low_coef;
        n_high_coef = r_high_coef;
        n_low_gain  = r_low_gain;
        n_mid_gain  = r_mid_gain;
        n_high_gain = r_high_gain;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LOW_COEF:  n_low_coef  = i_cfg_data;
                REG_HIGH_COEF: n_high_coef = i_cfg_data;
                REG_LOW_GAIN:  n_low_gain  = i_cfg_data;
                REG_MID_GAIN:  n_mid_gain  = i_cfg_data;
                REG_HIGH_GAIN: n_high_gain = i_cfg_data;
                default: ;
            endcase
        end

        if (r_m_tvalid && i_m_tready) n_m_tvalid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_samp[c] = i_s_tdata[c*SAMPLE_W +: SAMPLE_W];
                    end
                    n_ch    = '0;
                    n_stage = '0;
                    n_band  = BAND_LOW;
                    n_term  = TERM_LOW;
                end
            end
            ST_DIFF: begin
                n_diff = diff_val;
                n_acc  = '0;
            end
            ST_MUL_LO, ST_MUL_HI, ST_OMUL_LO: begin
                n_acc = acc_add;
            end
            ST_UPDATE: begin
                if (r_band == BAND_HIGH) n_high[r_ch][r_stage] = pole_new;
                else                     n_low[r_ch][r_stage]  = pole_new;
                n_in = pole_new;
                if (last_stage) begin
                    // stage stays at the last pole so the band step reads both outputs
                    if (r_band == BAND_LOW) begin
                        n_band  = BAND_HIGH;
                        n_stage = '0;
                    end else begin
                        n_term = TERM_LOW;
                    end
                end else begin
                    n_stage = r_stage + SW'(1);
                end
            end
            ST_OPND: begin
                n_diff = opnd_val;
                if (r_term == TERM_LOW) n_acc = '0;
            end
            ST_OMUL_HI: begin
                n_acc = acc_add;
                case (r_term)
                    TERM_LOW: n_term = TERM_MID;
                    TERM_MID: n_term = TERM_HIGH;
                    default:  n_term = r_term;
                endcase
            end
            ST_FINISH: begin
                n_res[r_ch] = res_val;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (CW'(c) == r_ch) begin
                        for (int k = DELAY - 1; k > 0; k--) begin
                            n_hist[c][k] = r_hist[c][k-1];
                        end
                        n_hist[c][0] = r_samp[c];
                    end
                end
                if (!last_ch) begin
                    n_ch    = r_ch + CW'(1);
                    n_stage = '0;
                    n_band  = BAND_LOW;
                    n_term  = TERM_LOW;
                end
            end
            ST_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_m_tdata[c*SAMPLE_W +: SAMPLE_W] = r_res[c];
                    end
                    n_m_tvalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_stage     <= '0;
            r_band      <= BAND_LOW;
            r_term      <= TERM_LOW;
            r_m_tvalid  <= 1'b0;
            r_low_coef  <= LOW_COEF_RST;
            r_high_coef <= HIGH_COEF_RST;
            r_low_gain  <= GAIN_RST;
            r_mid_gain  <= GAIN_RST;
            r_high_gain <= GAIN_RST;
            r_low       <= '{default: '0};
            r_high      <= '{default: '0};
            r_hist      <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_stage     <= n_stage;
            r_band      <= n_band;
            r_term      <= n_term;
            r_m_tvalid  <= n_m_tvalid;
            r_low_coef  <= n_low_coef;
            r_high_coef <= n_high_coef;
            r_low_gain  <= n_low_gain;
            r_mid_gain  <= n_mid_gain;
            r_high_gain <= n_high_gain;
            r_low       <= n_low;
            r_high      <= n_high;
            r_hist      <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_samp    <= n_samp;
        r_res     <= n_res;
        r_diff    <= n_diff;
        r_in      <= n_in;
        r_acc     <= n_acc;
        r_m_tdata <= n_m_tdata;
    end

endmodule

/* sv/steq_checker.sv */
// ----------------------------------------------------------------------------
// steq_checker
// Port-level checks for the equalizer: output hold under stall, busy after an
// item is taken, and results only appearing as the block returns to ready.
// ----------------------------------------------------------------------------
module steq_checker #(
    parameter int CHANNELS = steq_pkg::CHANNELS_DEF
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_s_tvalid,
    input logic                                   o_s_tready,
    input logic                                   o_m_tvalid,
    input logic                                   i_m_tready,
    input logic [CHANNELS*steq_pkg::SAMPLE_W-1:0] o_m_tdata
);
    import steq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after an item was taken");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after acceptance");

    a_result_with_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("result raised while block still busy");

endmodule

bind stereo_three_band_equalizer_unit steq_checker #(.CHANNELS(CHANNELS)) u_steq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* dv/stereo_three_band_equalizer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_three_band_equalizer_unit_tb
// Streams stereo frames through the equalizer under bursty input and a
// stalling output. A scoreboard keeps a bit-exact fixed-point copy of the
// filter state and compares every equalized frame in order. The run steps
// through several coefficient and gain settings: reset values, zero,
// full scale, coefficients above 2.0, and writes to unused register indexes.
// ----------------------------------------------------------------------------
module stereo_three_band_equalizer_unit_tb;
    import steq_pkg::*;

    localparam int CH             = CHANNELS_DEF;
    localparam int FRAC_BITS      = FRAC_BITS_DEF;
    localparam int REG_COUNT      = 5;
    localparam int IDX_SPAN       = 1 << CFG_IDX_W;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLDOFF_AT     = 400;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_FRAMES   = 100;
    localparam int OUT_SHIFT      = FRAC_BITS + COEF_FRAC;
    localparam int SAMPLE_MAX     = 32767;
    localparam int SAMPLE_MIN     = -32768;

    localparam logic [COEF_W-1:0] COEF_TWO = 18'd131072;  // 2.0 in Q.16
    localparam logic [COEF_W-1:0] REG_MAX  = '1;

    localparam longint POLE_MAX = (64'sd1 <<< (POLE_W - 1)) - 1;
    localparam longint POLE_MIN = -POLE_MAX - 1;

    localparam int DIRECTED_LEN = 19;
    localparam int DIRECTED [DIRECTED_LEN][2] = '{
        '{0, 0}, '{32767, -32768}, '{-32768, 32767},
        '{32767, 32767}, '{32767, 32767}, '{32767, 32767},
        '{-32768, -32768}, '{-32768, -32768}, '{-32768, -32768},
        '{-1, 1}, '{1, -1}, '{21845, -21846}, '{-21846, 21845},
        '{0, 0}, '{0, 0}, '{0, 0},
        '{32767, 0}, '{0, -32768}, '{-1, -1}
    };

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample right_sample;
        t_sample left_sample;
    } t_frame;

    class eq_scoreboard;
        logic [COEF_W-1:0] regs [REG_COUNT];
        longint            poles [2][CH][STAGES];  // first index: t_band
        longint            history [CH][DELAY];
        t_frame            expected_frames [$];
        int                errors;

        function new();
            regs[REG_LOW_COEF]  = LOW_COEF_RST;
            regs[REG_HIGH_COEF] = HIGH_COEF_RST;
            regs[REG_LOW_GAIN]  = GAIN_RST;
            regs[REG_MID_GAIN]  = GAIN_RST;
            regs[REG_HIGH_GAIN] = GAIN_RST;
            foreach (poles[b, c, s]) poles[b][c][s] = 0;
            foreach (history[c, k]) history[c][k] = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
            if (idx < REG_COUNT) regs[idx] = value;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // four one-pole stages; arithmetic shift gives the floor of the delta
        function longint run_cascade(t_band band, int c, longint x, longint coef);
            longint stage_in;
            longint pole;
            stage_in = x;
            for (int s = 0; s < STAGES; s++) begin
                pole = poles[band][c][s];
                pole = pole + (((stage_in - pole) * coef) >>> COEF_FRAC);
                if (pole > POLE_MAX) pole = POLE_MAX;
                if (pole < POLE_MIN) pole = POLE_MIN;
                poles[band][c][s] = pole;
                stage_in = pole;
            end
            return stage_in;
        endfunction

        function t_sample equalize_sample(int c, t_sample smp);
            longint x;
            longint delayed;
            longint low_band;
            longint mid_band;
            longint high_band;
            longint acc;
            longint scaled;
            x         = longint'(smp) <<< FRAC_BITS;
            delayed   = history[c][DELAY-1] <<< FRAC_BITS;
            low_band  = run_cascade(BAND_LOW, c, x, longint'(regs[REG_LOW_COEF]));
            high_band = delayed - run_cascade(BAND_HIGH, c, x, longint'(regs[REG_HIGH_COEF]));
            mid_band  = delayed - (high_band + low_band);
            acc = low_band * longint'(regs[REG_LOW_GAIN])
                + mid_band * longint'(regs[REG_MID_GAIN])
                + high_band * longint'(regs[REG_HIGH_GAIN]);
            // truncate toward zero, then clip to 16 bits
            scaled = (acc >= 0) ? (acc >>> OUT_SHIFT) : -((-acc) >>> OUT_SHIFT);
            if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
            if (scaled < SAMPLE_MIN) scaled = SAMPLE_MIN;
            for (int k = DELAY - 1; k > 0; k--) history[c][k] = history[c][k-1];
            history[c][0] = longint'(smp);
            return t_sample'(scaled);
        endfunction

        function void note_frame(t_frame f);
            t_frame eq;
            eq.left_sample  = equalize_sample(0, f.left_sample);
            eq.right_sample = equalize_sample(1, f.right_sample);
            expected_frames.push_back(eq);
        endfunction

        function void check_frame(t_frame got);
            t_frame want;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame left=%0d right=%0d",
                         $time, got.left_sample, got.right_sample);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.left_sample !== want.left_sample) begin
                $display("%0t: left mismatch expected=%0d actual=%0d",
                         $time, want.left_sample, got.left_sample);
                errors++;
            end
            if (got.right_sample !== want.right_sample) begin
                $display("%0t: right mismatch expected=%0d actual=%0d",
                         $time, want.right_sample, got.right_sample);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    t_frame               s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    t_frame               m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    eq_scoreboard sb = new();
    int           frames_accepted = 0;

    stereo_three_band_equalizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_frame(m_tdata);
    end

    // output back-pressure: ready runs, optional stalls, one long hold-off
    initial begin : receiver
        bit holdoff_done;
        holdoff_done = 1'b0;
        forever begin
            if (!holdoff_done && frames_accepted >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 200)) @(posedge i_clk);
                if ($urandom_range(0, 3) != 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 80)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? t_sample'(SAMPLE_MAX) : t_sample'(SAMPLE_MIN);
            1, 2:    return t_sample'(int'($urandom_range(0, 1024)) - 512);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COEF_TWO;
            2:       return COEF_W'($urandom_range(COEF_TWO + 1, REG_MAX));
            3, 4, 5: return COEF_W'($urandom_range(1, 16384));  // usual crossover range
            default: return COEF_W'($urandom_range(1, COEF_TWO - 1));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return REG_MAX;
            2:       return GAIN_RST;
            default: return COEF_W'($urandom_range(0, REG_MAX));
        endcase
    endfunction

    task automatic send_frame(input t_frame f);
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        do @(posedge i_clk); while (!s_tready);
        sb.note_frame(f);
        frames_accepted++;
    endtask

    task automatic stream_frames(input int count);
        t_frame f;
        int     burst_left;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++) begin
            f.left_sample  = random_sample();
            f.right_sample = random_sample();
            send_frame(f);
            burst_left--;
            if (burst_left == 0 && n != count - 1) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 120)) @(posedge i_clk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_setting(input logic [COEF_W-1:0] low_coef, high_coef,
                                 input logic [COEF_W-1:0] low_gain, mid_gain, high_gain);
        write_reg(REG_LOW_COEF, low_coef);
        write_reg(REG_HIGH_COEF, high_coef);
        write_reg(REG_LOW_GAIN, low_gain);
        write_reg(REG_MID_GAIN, mid_gain);
        write_reg(REG_HIGH_GAIN, high_gain);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_frame f;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, steps and bit patterns at the reset settings
        for (int k = 0; k < DIRECTED_LEN; k++) begin
            f.left_sample  = t_sample'(DIRECTED[k][0]);
            f.right_sample = t_sample'(DIRECTED[k][1]);
            send_frame(f);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // coefficients of 2.0 and full-scale gains drive the output into saturation
        apply_setting(COEF_TWO, COEF_TWO, REG_MAX, REG_MAX, REG_MAX);
        stream_frames(60);
        wait_drained();

        apply_setting('0, '0, '0, '0, '0);
        stream_frames(40);
        wait_drained();

        // coefficients above 2.0: cascades diverge and poles clip
        apply_setting(REG_MAX, REG_MAX, random_gain(), random_gain(), random_gain());
        stream_frames(60);
        wait_drained();

        // writes to unused indexes, then every register is set back to its reset value
        for (int k = REG_COUNT; k < IDX_SPAN; k++) begin
            write_reg(CFG_IDX_W'(k), COEF_W'($urandom_range(0, REG_MAX)));
        end
        apply_setting(LOW_COEF_RST, HIGH_COEF_RST, GAIN_RST, GAIN_RST, GAIN_RST);
        stream_frames(60);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_setting(random_coef(), random_coef(), random_gain(), random_gain(),
                          random_gain());
            stream_frames(PHASE_FRAMES);
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/steq_pkg.sv
sv/stereo_three_band_equalizer_unit.sv
sv/steq_checker.sv
dv/stereo_three_band_equalizer_unit_tb.sv
